>>> rtl/ccp_pkg.sv
package ccp_pkg;

  localparam int COORD_W   = 24;
  localparam int IDX_W     = 10;
  localparam int DEPTH     = 1 << IDX_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int VCNT_W    = 11;
  localparam int ULEN_W    = 23;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIN_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_CX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_CY     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_CZ     = 3'd6;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_EDGE   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [IDX_W-1:0]          first_index;
    logic [IDX_W-1:0]          second_index;
    logic signed [COORD_W-1:0] write_x;
    logic signed [COORD_W-1:0] write_y;
    logic signed [COORD_W-1:0] write_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic                      moved;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_SUM,
    ST_LIMSQ,
    ST_TEST,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_NUM,
    ST_DIV,
    ST_DIV_WAIT,
    ST_APPLY,
    ST_WR_A,
    ST_WR_B,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_SQ,
    OP_SUM,
    OP_LIMSQ,
    OP_ROOT,
    OP_NUM,
    OP_DIV,
    OP_APPLY,
    OP_WR_A,
    OP_WR_B,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic go;
    logic root_done;
    logic div_done;
  } sts_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd8388607;
    lo = -32'sd8388608;
    if (v > hi) return hi[COORD_W-1:0];
    else if (v < lo) return lo[COORD_W-1:0];
    else return v[COORD_W-1:0];
  endfunction

endpackage

>>> rtl/ccp_isqrt.sv
module ccp_isqrt
  import ccp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic [30:0] root,
  output logic        done
);

  logic [61:0] rad_r;
  logic [31:0] rem_r;
  logic [30:0] root_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [33:0] rem2;
  logic [33:0] trial;

  // one result bit per cycle, two radicand bits consumed
  assign rem2  = {rem_r, rad_r[61:60]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == 5'd0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd30;
      end else if (run_r) begin
        if (cnt_r == 5'd0) run_r <= 1'b0;
        else cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r <= {rad_r[59:0], 2'b00};
      if (rem2 >= trial) begin
        rem_r  <= 32'(rem2 - trial);
        root_r <= {root_r[29:0], 1'b1};
      end else begin
        rem_r  <= rem2[31:0];
        root_r <= {root_r[29:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

>>> rtl/ccp_divider.sv
module ccp_divider
  import ccp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [58:0] dividend,
  input  logic [30:0] divisor,
  output logic [28:0] quotient,
  output logic        done
);

  logic [30:0] rem_r;
  logic [28:0] low_r;
  logic [28:0] q_r;
  logic [30:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [31:0] rem2;

  // quotient is known to fit 29 bits, so the top part starts below the divisor
  assign rem2 = {rem_r, low_r[28]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == 5'd0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd28;
      end else if (run_r) begin
        if (cnt_r == 5'd0) run_r <= 1'b0;
        else cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[58:29]};
      low_r <= dividend[28:0];
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (run_r) begin
      low_r <= {low_r[27:0], 1'b0};
      if (rem2 >= {1'b0, dvs_r}) begin
        rem_r <= 31'(rem2 - {1'b0, dvs_r});
        q_r   <= {q_r[27:0], 1'b1};
      end else begin
        rem_r <= rem2[30:0];
        q_r   <= {q_r[27:0], 1'b0};
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

>>> rtl/ccp_ctrl.sv
module ccp_ctrl
  import ccp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      ST_IDLE:      if (start) state_nxt = ST_LOAD;
      ST_LOAD: begin
        case (sts.cmd)
          CMD_WRITE: state_nxt = ST_WR_A;
          CMD_READ:  state_nxt = ST_DONE;
          default:   state_nxt = ST_SQ;
        endcase
      end
      ST_SQ:        state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_LIMSQ;
      ST_LIMSQ:     state_nxt = ST_TEST;
      ST_TEST:      state_nxt = sts.go ? ST_ROOT : ST_WR_A;
      ST_ROOT:      state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (sts.root_done) begin
          state_nxt = ST_NUM;
          axis_nxt  = 2'd0;
        end
      end
      ST_NUM:       state_nxt = ST_DIV;
      ST_DIV:       state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (sts.div_done) state_nxt = ST_APPLY;
      ST_APPLY: begin
        if (axis_r == 2'd2) begin
          state_nxt = ST_WR_A;
        end else begin
          state_nxt = ST_NUM;
          axis_nxt  = axis_r + 2'd1;
        end
      end
      ST_WR_A:      state_nxt = (sts.cmd == CMD_EDGE) ? ST_WR_B : ST_DONE;
      ST_WR_B:      state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.axis = axis_r;
    ctl.op   = OP_NONE;
    unique case (state_r)
      ST_IDLE:  ctl.op = start ? OP_CAPTURE : OP_NONE;
      ST_LOAD:  ctl.op = OP_LOAD;
      ST_SQ:    ctl.op = OP_SQ;
      ST_SUM:   ctl.op = OP_SUM;
      ST_LIMSQ: ctl.op = OP_LIMSQ;
      ST_ROOT:  ctl.op = OP_ROOT;
      ST_NUM:   ctl.op = OP_NUM;
      ST_DIV:   ctl.op = OP_DIV;
      ST_APPLY: ctl.op = OP_APPLY;
      ST_WR_A:  ctl.op = OP_WR_A;
      ST_WR_B:  ctl.op = OP_WR_B;
      ST_DONE:  ctl.op = OP_EMIT;
      default:  ctl.op = OP_NONE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/ccp_datapath.sv
module ccp_datapath
  import ccp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output out_item_t            out_data
);

  // configuration
  logic [VCNT_W-1:0]         vcount_r;
  logic [ULEN_W-1:0]         rest_r;
  logic [ULEN_W-1:0]         strain_r;
  logic [ULEN_W-1:0]         radius_r;
  logic signed [COORD_W-1:0] ctr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 11'd1024;
      rest_r   <= 23'd73400;
      strain_r <= 23'd419430;
      radius_r <= 23'd671089;
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:  vcount_r <= cfg_wdata[VCNT_W-1:0];
        CFG_REST_LENGTH:   rest_r   <= cfg_wdata[ULEN_W-1:0];
        CFG_STRAIN_LIMIT:  strain_r <= cfg_wdata[ULEN_W-1:0];
        CFG_SPHERE_RADIUS: radius_r <= cfg_wdata[ULEN_W-1:0];
        CFG_SPHERE_CX:     ctr_r[0] <= signed'(cfg_wdata);
        CFG_SPHERE_CY:     ctr_r[1] <= signed'(cfg_wdata);
        CFG_SPHERE_CZ:     ctr_r[2] <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // vertex store, two registered read ports, one write port
  logic signed [COORD_W-1:0] mem_x [DEPTH];
  logic signed [COORD_W-1:0] mem_y [DEPTH];
  logic signed [COORD_W-1:0] mem_z [DEPTH];
  logic signed [COORD_W-1:0] rda_r [3];
  logic signed [COORD_W-1:0] rdb_r [3];
  logic signed [COORD_W-1:0] na_r  [3];
  logic signed [COORD_W-1:0] nb_r  [3];
  in_item_t                  in_r;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic signed [COORD_W-1:0] wr_d  [3];

  always_comb begin
    wr_en   = (ctl.op == OP_WR_A && in_r.cmd != CMD_READ) || (ctl.op == OP_WR_B);
    wr_addr = (ctl.op == OP_WR_B) ? in_r.second_index : in_r.first_index;
    for (int i = 0; i < 3; i++) wr_d[i] = (ctl.op == OP_WR_B) ? nb_r[i] : na_r[i];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_d[0];
      mem_y[wr_addr] <= wr_d[1];
      mem_z[wr_addr] <= wr_d[2];
    end
    if (ctl.op == OP_CAPTURE) begin
      rda_r[0] <= mem_x[in_data.first_index];
      rda_r[1] <= mem_y[in_data.first_index];
      rda_r[2] <= mem_z[in_data.first_index];
      rdb_r[0] <= mem_x[in_data.second_index];
      rdb_r[1] <= mem_y[in_data.second_index];
      rdb_r[2] <= mem_z[in_data.second_index];
    end
  end

  // arithmetic registers
  logic signed [COORD_W-1:0] a_r [3];
  logic signed [COORD_W-1:0] b_r [3];
  logic signed [COORD_W:0]   d_r [3];
  logic signed [49:0]        sq_p [3];
  logic [48:0]               sq_r [3];
  logic [49:0]               s_r;
  logic [23:0]               factor;
  logic [46:0]               lim_p, lim_prod_r;
  logic [45:0]               rr_r;
  logic [26:0]               lim_r;
  logic [53:0]               limsq_r;
  logic [26:0]               k_r;
  logic [51:0]               num_r;
  logic                      neg_r;
  logic [COORD_W:0]          dmag;
  logic signed [COORD_W:0]   dsel;
  logic signed [COORD_W-1:0] wsel [3];
  logic [30:0]               root_q;
  logic                      root_done;
  logic [28:0]               quot;
  logic                      div_done;
  logic [58:0]               div_in;
  logic [VCNT_W-1:0]         last_idx;
  logic                      fa, fb, go;

  assign wsel[0] = in_r.write_x;
  assign wsel[1] = in_r.write_y;
  assign wsel[2] = in_r.write_z;

  assign factor = 24'h100000 + {1'b0, strain_r};
  assign lim_p  = rest_r * factor;

  always_comb begin
    for (int i = 0; i < 3; i++) sq_p[i] = d_r[i] * d_r[i];
  end

  assign dsel = d_r[ctl.axis];
  assign dmag = dsel[COORD_W] ? 25'(-dsel) : 25'(dsel);

  // index 0 and count-1 do not move
  assign last_idx = vcount_r - 11'd1;
  assign fa = (in_r.first_index == '0) || ({1'b0, in_r.first_index} == last_idx);
  assign fb = (in_r.second_index == '0) || ({1'b0, in_r.second_index} == last_idx);

  // squared limit can reach past the squared length range, compare at full width
  always_comb begin
    if (in_r.cmd == CMD_SPHERE)
      go = (s_r != '0) && (s_r < 50'(rr_r));
    else
      go = (in_r.first_index != in_r.second_index) && (54'(s_r) > limsq_r) && !(fa && fb);
  end

  assign div_in = 59'({num_r, 6'b000000}) + 59'(root_q[30:1]);

  // per-axis correction
  logic signed [31:0] tv, dv, av, bv, cv, ev, hmag, hv;
  always_comb begin
    tv   = neg_r ? -$signed({3'b000, quot}) : $signed({3'b000, quot});
    dv   = 32'(dsel);
    av   = 32'(a_r[ctl.axis]);
    bv   = 32'(b_r[ctl.axis]);
    cv   = 32'(ctr_r[ctl.axis]);
    ev   = dv - tv;
    hmag = (ev < 0) ? ((-ev) >>> 1) : (ev >>> 1);
    hv   = (ev < 0) ? -hmag : hmag;
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_CAPTURE: in_r <= in_data;
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i]  <= rda_r[i];
          b_r[i]  <= (in_r.cmd == CMD_EDGE) ? rdb_r[i] : '0;
          nb_r[i] <= (in_r.cmd == CMD_EDGE) ? rdb_r[i] : '0;
          na_r[i] <= (in_r.cmd == CMD_WRITE) ? wsel[i] : rda_r[i];
          d_r[i]  <= 25'(rda_r[i]) -
                     ((in_r.cmd == CMD_SPHERE) ? 25'(ctr_r[i]) : 25'(rdb_r[i]));
        end
      end
      OP_SQ: begin
        for (int i = 0; i < 3; i++) sq_r[i] <= sq_p[i][48:0];
        lim_prod_r <= lim_p;
        rr_r       <= radius_r * radius_r;
      end
      OP_SUM: begin
        s_r   <= 50'(sq_r[0]) + 50'(sq_r[1]) + 50'(sq_r[2]);
        lim_r <= lim_prod_r[46:20];
      end
      OP_LIMSQ: begin
        limsq_r <= lim_r * lim_r;
        k_r     <= (in_r.cmd == CMD_EDGE) ? lim_r : 27'(radius_r);
      end
      OP_NUM: begin
        num_r <= dmag * k_r;
        neg_r <= dsel[COORD_W];
      end
      OP_APPLY: begin
        if (in_r.cmd == CMD_SPHERE) begin
          na_r[ctl.axis] <= sat_coord(cv + tv);
        end else if (fa) begin
          nb_r[ctl.axis] <= sat_coord(bv + ev);
        end else if (fb) begin
          na_r[ctl.axis] <= sat_coord(av - ev);
        end else begin
          na_r[ctl.axis] <= sat_coord(av - hv);
          nb_r[ctl.axis] <= sat_coord(bv + (ev - hv));
        end
      end
      default: ;
    endcase
  end

  ccp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.op == OP_ROOT),
    .radicand ({s_r, 12'h000}),
    .root     (root_q),
    .done     (root_done)
  );

  ccp_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.op == OP_DIV),
    .dividend (div_in),
    .divisor  (root_q),
    .quotient (quot),
    .done     (div_done)
  );

  // result register
  logic      out_valid_r;
  out_item_t out_r;
  logic      moved;

  always_comb begin
    moved = (in_r.cmd == CMD_WRITE);
    for (int i = 0; i < 3; i++) begin
      if (na_r[i] != a_r[i]) moved = 1'b1;
      if (in_r.cmd == CMD_EDGE && nb_r[i] != b_r[i]) moved = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= (ctl.op == OP_EMIT);
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT) begin
      out_r.first_x  <= na_r[0];
      out_r.first_y  <= na_r[1];
      out_r.first_z  <= na_r[2];
      out_r.second_x <= nb_r[0];
      out_r.second_y <= nb_r[1];
      out_r.second_z <= nb_r[2];
      out_r.moved    <= (in_r.cmd != CMD_READ) && moved;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.cmd       = in_r.cmd;
  assign sts.go        = go;
  assign sts.root_done = root_done;
  assign sts.div_done  = div_done;

endmodule

>>> rtl/cloth_constraint_projector.sv
// cloth constraint projector: a 1024-entry store of q4.20 vertex positions with four
// commands (write, read, sphere push, edge strain limit). a transaction is taken when
// start is high and busy is low; exactly one result comes back on out_data with a
// one-cycle out_valid strobe, and the receiver cannot stall it, so capture it on that
// edge. a read only loads the entry, a write loads and then stores it; sphere push and
// strain limit first square the length and test it against the limit, and when a
// correction is applied they also run the 31-step square root and three 29-step
// divisions, one per axis, in the shared iterative units before writing back.
// the store holds no reset value: read only entries that were written.
// configuration writes are taken at any edge but are meant for idle periods only.
module cloth_constraint_projector
  import ccp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // command and status between sequencer and datapath
  ctl_t ctl;
  sts_t sts;

  ccp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // vertex store, config registers, sqrt and divider live here
  ccp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an accepted transaction always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // the result strobe only comes once the sequencer is back to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // one strobe per transaction, never two in a row
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

endmodule

>>> verif/tb_cloth_constraint_projector.sv
`timescale 1ns / 100ps

module tb_cloth_constraint_projector;
  import ccp_pkg::*;

  // predicts each result from its own copy of the vertex store and registers
  class proj_scoreboard;
    logic signed [COORD_W-1:0] pos_x [DEPTH];
    logic signed [COORD_W-1:0] pos_y [DEPTH];
    logic signed [COORD_W-1:0] pos_z [DEPTH];
    logic [VCNT_W-1:0]         vcount;
    logic [ULEN_W-1:0]         rest_len;
    logic [ULEN_W-1:0]         tau;
    logic [ULEN_W-1:0]         radius;
    logic signed [COORD_W-1:0] center [3];
    out_item_t                 pending [$];
    int                        errors;

    function void reset_regs();
      vcount    = 11'd1024;
      rest_len  = 23'd73400;
      tau       = 23'd419430;
      radius    = 23'd671089;
      center[0] = '0;
      center[1] = '0;
      center[2] = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_VERTEX_COUNT:  vcount    = val[VCNT_W-1:0];
        CFG_REST_LENGTH:   rest_len  = val[ULEN_W-1:0];
        CFG_STRAIN_LIMIT:  tau       = val[ULEN_W-1:0];
        CFG_SPHERE_RADIUS: radius    = val[ULEN_W-1:0];
        CFG_SPHERE_CX:     center[0] = val;
        CFG_SPHERE_CY:     center[1] = val;
        CFG_SPHERE_CZ:     center[2] = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // nearest, ties away from zero
    function longint round_div(longint num, longint unsigned den);
      longint unsigned m;
      longint unsigned q;
      m = (num < 0) ? longint'(-num) : longint'(num);
      q = (m + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function bit pinned(logic [IDX_W-1:0] idx);
      logic [VCNT_W-1:0] last;
      last = vcount - 11'd1;
      return (idx == 0) || ({1'b0, idx} == last);
    endfunction

    function void note_input(in_item_t it);
      longint a [3];
      longint b [3];
      longint na [3];
      longint nb [3];
      longint d [3];
      longint unsigned s;
      longint unsigned lim;
      longint unsigned len;
      longint t;
      longint e;
      longint h;
      bit fa;
      bit fb;
      bit moved;
      int sa;
      int sb;
      out_item_t res;
      sa = int'(it.first_index);
      sb = int'(it.second_index);
      moved = 0;
      a[0] = longint'(pos_x[sa]); a[1] = longint'(pos_y[sa]); a[2] = longint'(pos_z[sa]);
      for (int i = 0; i < 3; i++) begin
        na[i] = a[i];
        b[i] = 0;
        nb[i] = 0;
      end
      case (it.cmd)
        CMD_WRITE: begin
          na[0] = longint'(it.write_x);
          na[1] = longint'(it.write_y);
          na[2] = longint'(it.write_z);
          moved = 1;
        end
        CMD_SPHERE: begin
          s = 0;
          for (int i = 0; i < 3; i++) begin
            d[i] = a[i] - longint'(center[i]);
            s += longint'(d[i] * d[i]);
          end
          // strictly inside and off center: push out radially
          if (s != 0 && s < longint'(radius) * longint'(radius)) begin
            len = int_sqrt(s << 12);
            for (int i = 0; i < 3; i++)
              na[i] = clamp(longint'(center[i]) +
                            round_div(d[i] * longint'(radius) * 64, len));
          end
        end
        CMD_EDGE: begin
          b[0] = longint'(pos_x[sb]); b[1] = longint'(pos_y[sb]); b[2] = longint'(pos_z[sb]);
          s = 0;
          for (int i = 0; i < 3; i++) begin
            nb[i] = b[i];
            d[i] = a[i] - b[i];
            s += longint'(d[i] * d[i]);
          end
          lim = (longint'(rest_len) * ((64'd1 << 20) + longint'(tau))) >> 20;
          fa = pinned(it.first_index);
          fb = pinned(it.second_index);
          if (sa != sb && s > lim * lim && !(fa && fb)) begin
            len = int_sqrt(s << 12);
            for (int i = 0; i < 3; i++) begin
              t = round_div(d[i] * longint'(lim) * 64, len);
              e = d[i] - t;
              if (fa) begin
                nb[i] = clamp(b[i] + e);
              end else if (fb) begin
                na[i] = clamp(a[i] - e);
              end else begin
                // odd excess: first end takes the half rounded toward zero
                h = ((e < 0) ? -e : e) >>> 1;
                if (e < 0) h = -h;
                na[i] = clamp(a[i] - h);
                nb[i] = clamp(b[i] + (e - h));
              end
            end
          end
        end
        default: ;
      endcase
      if (it.cmd != CMD_READ) begin
        for (int i = 0; i < 3; i++) if (na[i] != a[i]) moved = 1;
        pos_x[sa] = na[0][COORD_W-1:0];
        pos_y[sa] = na[1][COORD_W-1:0];
        pos_z[sa] = na[2][COORD_W-1:0];
      end
      if (it.cmd == CMD_EDGE) begin
        for (int i = 0; i < 3; i++) if (nb[i] != b[i]) moved = 1;
        pos_x[sb] = nb[0][COORD_W-1:0];
        pos_y[sb] = nb[1][COORD_W-1:0];
        pos_z[sb] = nb[2][COORD_W-1:0];
        if (sa == sb) for (int i = 0; i < 3; i++) na[i] = nb[i];
      end
      res.first_x  = na[0][COORD_W-1:0];
      res.first_y  = na[1][COORD_W-1:0];
      res.first_z  = na[2][COORD_W-1:0];
      res.second_x = nb[0][COORD_W-1:0];
      res.second_y = nb[1][COORD_W-1:0];
      res.second_z = nb[2][COORD_W-1:0];
      res.moved    = moved;
      pending = {pending, res};
    endfunction

    function void cmp_field(string nm, logic [COORD_W-1:0] exp_v, logic [COORD_W-1:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, exp_v, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      cmp_field("first_x", want.first_x, got.first_x);
      cmp_field("first_y", want.first_y, got.first_y);
      cmp_field("first_z", want.first_z, got.first_z);
      cmp_field("second_x", want.second_x, got.second_x);
      cmp_field("second_y", want.second_y, got.second_y);
      cmp_field("second_z", want.second_z, got.second_z);
      cmp_field("moved", {23'd0, want.moved}, {23'd0, got.moved});
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  proj_scoreboard sb;
  bit             written [DEPTH];
  int             pool [$];       // indices that hold a defined position
  int             burst_left;
  int             idle_cycles;

  cloth_constraint_projector uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitors: a transaction is taken when start is high and busy is low
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_data);
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // watchdog on cycles where no transaction moves in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles > 5000) begin
      $display("tb_cloth_constraint_projector failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // holds start until the block takes the transaction; returns on that edge
  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= it;
    if (it.cmd == CMD_WRITE && !written[it.first_index]) begin
      written[it.first_index] = 1;
      pool = {pool, int'(it.first_index)};
    end
    do @(posedge clk); while (busy);
  endtask

  // lower start and let every pending result come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_item_t mk(cmd_t c, int ia, int ib, int x, int y, int z);
    in_item_t it;
    it.cmd          = c;
    it.first_index  = IDX_W'(ia);
    it.second_index = IDX_W'(ib);
    it.write_x      = COORD_W'(x);
    it.write_y      = COORD_W'(y);
    it.write_z      = COORD_W'(z);
    return it;
  endfunction

  function automatic int pick_defined();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic int rand_coord();
    return int'(signed'(24'($urandom)));
  endfunction

  // a coordinate within half the sphere radius of the given center coordinate
  function automatic int near(int c);
    longint v;
    int span;
    span = (sb.radius == 0) ? 4 : int'(sb.radius);
    v = longint'(c) + $signed($urandom_range(0, span)) - span / 2;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return int'(v);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int sel;
    int ia;
    sel = $urandom_range(0, 99);
    it = mk(CMD_READ, pick_defined(), $urandom_range(0, DEPTH - 1), rand_coord(), rand_coord(),
            rand_coord());
    if (sel < 30) begin
      it.cmd = CMD_WRITE;
      case ($urandom_range(0, 4))
        0: ia = $urandom_range(0, DEPTH - 1);
        1: ia = ($urandom_range(0, 1) == 0) ? 0 : int'(sb.vcount - 11'd1) % DEPTH;
        default: ia = $urandom_range(0, 31);
      endcase
      it.first_index = IDX_W'(ia);
      case ($urandom_range(0, 2))
        0: ; // full range coordinates
        1: begin
          it.write_x = COORD_W'(near(sb.center[0]));
          it.write_y = COORD_W'(near(sb.center[1]));
          it.write_z = COORD_W'(near(sb.center[2]));
        end
        default: begin
          it.write_x = COORD_W'($signed($urandom_range(0, 400000)) - 200000);
          it.write_y = COORD_W'($signed($urandom_range(0, 400000)) - 200000);
          it.write_z = COORD_W'($signed($urandom_range(0, 400000)) - 200000);
        end
      endcase
    end else if (sel < 40) begin
      it.cmd = CMD_READ;
    end else if (sel < 62) begin
      it.cmd = CMD_SPHERE;
    end else begin
      it.cmd = CMD_EDGE;
      it.second_index = IDX_W'(pick_defined());
    end
    return it;
  endfunction

  initial begin
    logic [CFG_W-1:0] rv;
    sb = new();
    sb.reset_regs();
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed transactions under the reset settings
    send(mk(CMD_WRITE, 0, 1023, 8388607, -8388608, 0));
    send(mk(CMD_WRITE, 1023, 0, -8388608, 8388607, -1));
    send(mk(CMD_WRITE, 1, 0, 0, 0, 0));              // exactly at sphere center
    send(mk(CMD_WRITE, 2, 0, 100000, -50000, 20000)); // inside the sphere
    send(mk(CMD_WRITE, 3, 0, 671089, 0, 0));          // exactly on the surface
    send(mk(CMD_WRITE, 4, 0, 300001, 7, -300003));
    send(mk(CMD_WRITE, 5, 0, -1, -1, -1));
    send(mk(CMD_READ, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 1023, 1023, 0, 0, 0));
    send(mk(CMD_SPHERE, 1, 0, 0, 0, 0));
    send(mk(CMD_SPHERE, 2, 0, 0, 0, 0));
    send(mk(CMD_SPHERE, 3, 0, 0, 0, 0));
    send(mk(CMD_SPHERE, 0, 0, 0, 0, 0));
    send(mk(CMD_EDGE, 0, 1023, 0, 0, 0));            // both ends pinned
    send(mk(CMD_EDGE, 4, 4, 0, 0, 0));               // same vertex
    send(mk(CMD_EDGE, 1, 5, 0, 0, 0));               // short edge, untouched
    send(mk(CMD_EDGE, 4, 5, 0, 0, 0));               // both free, odd excess
    send(mk(CMD_EDGE, 0, 4, 0, 0, 0));               // first end pinned
    send(mk(CMD_EDGE, 2, 1023, 0, 0, 0));            // second end pinned
    send(mk(CMD_READ, 4, 0, 0, 0, 0));
    send(mk(CMD_READ, 5, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_reg(CFG_VERTEX_COUNT, 24'd2);
          set_reg(CFG_REST_LENGTH, 24'd1);
          set_reg(CFG_STRAIN_LIMIT, 24'd0);
          set_reg(CFG_SPHERE_RADIUS, 24'd0);
          set_reg(CFG_SPHERE_CX, 24'h800000);
          set_reg(CFG_SPHERE_CY, 24'h800000);
          set_reg(CFG_SPHERE_CZ, 24'h800000);
        end
        1: begin
          set_reg(CFG_VERTEX_COUNT, 24'd1024);
          set_reg(CFG_REST_LENGTH, 24'h7FFFFF);
          set_reg(CFG_STRAIN_LIMIT, 24'h7FFFFF);
          set_reg(CFG_SPHERE_RADIUS, 24'h7FFFFF);
          set_reg(CFG_SPHERE_CX, 24'h7FFFFF);
          set_reg(CFG_SPHERE_CY, 24'h7FFFFF);
          set_reg(CFG_SPHERE_CZ, 24'h7FFFFF);
        end
        default: begin
          set_reg(CFG_VERTEX_COUNT, 24'($urandom_range(2, 40)));
          set_reg(CFG_REST_LENGTH, 24'($urandom_range(1, 200000)));
          set_reg(CFG_STRAIN_LIMIT, 24'($urandom_range(0, 1 << 20)));
          set_reg(CFG_SPHERE_RADIUS, 24'($urandom_range(1000, 1 << 22)));
          rv = CFG_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
          set_reg(CFG_SPHERE_CX, rv);
          rv = CFG_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
          set_reg(CFG_SPHERE_CY, rv);
          rv = CFG_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
          set_reg(CFG_SPHERE_CZ, rv);
        end
      endcase
      for (int n = 0; n < 150; n++) send(rand_item());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_cloth_constraint_projector passed");
    end else begin
      $display("tb_cloth_constraint_projector failed");
    end
    $finish;
  end

endmodule
